[rtl/zos_pkg.sv]
// Shared types and field constants of the Z-order point sorter.
package zos_pkg;

    localparam int FIELD_W = 10;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

endpackage

[rtl/zos_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module zos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/zos_cmp.sv]
// Morton order comparator: true when point p strictly precedes point q.
module zos_cmp #(
    parameter int COORD_BITS = 10
) (
    input  logic [3*COORD_BITS-1:0] i_p,
    input  logic [3*COORD_BITS-1:0] i_q,
    output logic                    o_less
);

    logic [COORD_BITS-1:0] d    [3];
    logic [COORD_BITS-1:0] best [4];
    logic [1:0]            axis [4];
    logic [COORD_BITS-1:0] pc;
    logic [COORD_BITS-1:0] qc;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d[k] = i_p[k*COORD_BITS +: COORD_BITS] ^ i_q[k*COORD_BITS +: COORD_BITS];
        end
        best[0] = '0;
        axis[0] = 2'd0;
        // keep the axis whose difference has the highest set bit, first wins ties
        for (int k = 0; k < 3; k++) begin
            if (best[k] < d[k] && best[k] < (best[k] ^ d[k])) begin
                best[k+1] = d[k];
                axis[k+1] = 2'(k);
            end else begin
                best[k+1] = best[k];
                axis[k+1] = axis[k];
            end
        end
        case (axis[3])
            2'd1:    begin pc = i_p[COORD_BITS +: COORD_BITS];   qc = i_q[COORD_BITS +: COORD_BITS];   end
            2'd2:    begin pc = i_p[2*COORD_BITS +: COORD_BITS]; qc = i_q[2*COORD_BITS +: COORD_BITS]; end
            default: begin pc = i_p[COORD_BITS-1:0];             qc = i_q[COORD_BITS-1:0];             end
        endcase
        o_less = pc < qc;
    end

endmodule

[rtl/z_order_point_sort.sv]
// Z-order point sorter: loads go in one word per cycle; a load with tlast starts a stable
// bottom-up merge sort of the load indices into 3-D Morton order, during which tready is
// low. The sort first seeds the order memory, then runs ceil(log2 n) merge passes, whose
// speed is set by the chained reads of the order memory and then the point memory through
// their single read ports. A read word goes through the registered order memory read into
// the output register, holding while that register is full; its result word may wait in
// the output register while the next load word is taken.
module z_order_point_sort #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // coord_x, coord_y, coord_z, position
    input  logic        s_axis_tlast,  // last_point
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // point_index, zero pad
    output logic        m_axis_tuser   // index_valid
);
    import zos_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int XW = CW + 2;
    localparam int PW = 3 * COORD_BITS;
    localparam int EW = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int PX = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int IW = (AW > FIELD_W) ? AW : FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE, S_RDATA, S_INIT, S_RANGE, S_FETCH0, S_FETCH1, S_FETCH2, S_MERGE
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic                r_sorted;
    logic                r_bank;
    logic [CW-1:0]       r_init;
    logic [XW-1:0]       r_width, r_lo, r_mid, r_hi, r_a, r_b, r_o;
    logic                r_need_b, r_fsel;
    logic [AW-1:0]       r_va, r_vb;
    logic [PW-1:0]       r_pa, r_pb;
    logic [AW-1:0]       r_pos;
    logic                r_rd_ok;
    logic                r_ovalid;
    logic [FIELD_W-1:0]  r_oindex;
    logic                r_oflag;

    logic                s_acc, is_load, load_wr;
    logic [CW-1:0]       cnt_eff;
    logic [EW-1:0]       cx, cy, cz;
    logic [PW-1:0]       pt_wdata, pt_rdata;
    logic [PX-1:0]       pos_x, count_x;
    logic [AW-1:0]       rd_addr, b0_rdata, b1_rdata, src_rdata;
    logic [AW-1:0]       wr_addr, wr_data;
    logic                we0, we1, merge_wr;
    logic                a_live, b_live, less, take_b;
    logic [XW-1:0]       n_x, lo_w, lo_2w, mid, hi, width2;
    logic [IW-1:0]       idx_ext;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign is_load = (t_cmd'(s_axis_tuser) == CMD_LOAD);
    assign cnt_eff = r_sorted ? '0 : r_count;
    assign load_wr = s_acc && is_load && (cnt_eff < CW'(MAX_POINTS));

    assign cx = EW'(s_axis_tdata[9:0]);
    assign cy = EW'(s_axis_tdata[19:10]);
    assign cz = EW'(s_axis_tdata[29:20]);
    assign pt_wdata = {cz[COORD_BITS-1:0], cy[COORD_BITS-1:0], cx[COORD_BITS-1:0]};

    assign pos_x   = PX'(s_axis_tdata[39:30]);
    assign count_x = PX'(r_count);

    assign src_rdata = r_bank ? b1_rdata : b0_rdata;
    assign idx_ext   = IW'(src_rdata);

    assign n_x    = XW'(r_count);
    assign lo_w   = r_lo + r_width;
    assign lo_2w  = r_lo + (r_width << 1);
    assign mid    = (lo_w > n_x) ? n_x : lo_w;
    assign hi     = (lo_2w > n_x) ? n_x : lo_2w;
    assign width2 = r_width << 1;

    assign a_live   = r_a < r_mid;
    assign b_live   = r_b < r_hi;
    assign take_b   = b_live && (!a_live || less);
    assign merge_wr = (r_state == S_MERGE) && (a_live || b_live);

    always_comb begin
        unique case (r_state)
            S_IDLE:  rd_addr = pos_x[AW-1:0];
            S_RDATA: rd_addr = r_pos;
            default: rd_addr = r_fsel ? r_b[AW-1:0] : r_a[AW-1:0];
        endcase
        if (r_state == S_INIT) begin
            wr_addr = r_init[AW-1:0];
            wr_data = r_init[AW-1:0];
        end else begin
            wr_addr = r_o[AW-1:0];
            wr_data = take_b ? r_vb : r_va;
        end
        we0 = (r_state == S_INIT) || (merge_wr && r_bank);
        we1 = merge_wr && !r_bank;
    end

    zos_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_points (
        .i_clk  (i_clk),
        .i_we   (load_wr),
        .i_waddr(cnt_eff[AW-1:0]),
        .i_wdata(pt_wdata),
        .i_raddr(src_rdata),
        .o_rdata(pt_rdata)
    );

    zos_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_order0 (
        .i_clk  (i_clk),
        .i_we   (we0),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(b0_rdata)
    );

    zos_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_order1 (
        .i_clk  (i_clk),
        .i_we   (we1),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(b1_rdata)
    );

    zos_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
        .i_p   (r_pb),
        .i_q   (r_pa),
        .o_less(less)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sorted <= 1'b0;
            r_bank   <= 1'b0;
            r_ovalid <= 1'b0;
            r_need_b <= 1'b0;
            r_fsel   <= 1'b0;
        end else begin
            // the read data state refills the output register itself
            if (r_ovalid && m_axis_tready && r_state != S_RDATA) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (is_load) begin
                            r_sorted <= 1'b0;
                            r_count  <= load_wr ? cnt_eff + 1'b1 : cnt_eff;
                            if (s_axis_tlast) begin
                                r_init  <= '0;
                                r_state <= S_INIT;
                            end
                        end else begin
                            r_pos   <= pos_x[AW-1:0];
                            r_rd_ok <= r_sorted && (pos_x < count_x);
                            r_state <= S_RDATA;
                        end
                    end
                end
                S_RDATA: begin
                    // hold until the output register is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_oindex <= r_rd_ok ? idx_ext[FIELD_W-1:0] : '0;
                        r_oflag  <= r_rd_ok;
                        r_state  <= S_IDLE;
                    end
                end
                S_INIT: begin
                    if (r_init + 1'b1 == r_count) begin
                        r_bank <= 1'b0;
                        if (r_count < CW'(2)) begin
                            r_sorted <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_width <= XW'(1);
                            r_lo    <= '0;
                            r_state <= S_RANGE;
                        end
                    end else begin
                        r_init <= r_init + 1'b1;
                    end
                end
                S_RANGE: begin
                    if (r_lo >= n_x) begin
                        // pass done: swap banks, double run width
                        r_bank  <= !r_bank;
                        r_width <= width2;
                        r_lo    <= '0;
                        if (width2 >= n_x) begin
                            r_sorted <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_mid    <= mid;
                        r_hi     <= hi;
                        r_a      <= r_lo;
                        r_b      <= mid;
                        r_o      <= r_lo;
                        r_need_b <= mid < hi;
                        r_fsel   <= 1'b0;
                        r_state  <= S_FETCH0;
                    end
                end
                S_FETCH0: begin
                    r_state <= S_FETCH1;
                end
                S_FETCH1: begin
                    if (r_fsel) begin
                        r_vb <= src_rdata;
                    end else begin
                        r_va <= src_rdata;
                    end
                    r_state <= S_FETCH2;
                end
                S_FETCH2: begin
                    if (r_fsel) begin
                        r_pb <= pt_rdata;
                    end else begin
                        r_pa <= pt_rdata;
                    end
                    if (r_need_b) begin
                        r_need_b <= 1'b0;
                        r_fsel   <= 1'b1;
                        r_state  <= S_FETCH0;
                    end else begin
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    if (!a_live && !b_live) begin
                        r_lo    <= r_hi;
                        r_state <= S_RANGE;
                    end else begin
                        r_o <= r_o + 1'b1;
                        if (take_b) begin
                            r_b <= r_b + 1'b1;
                            if (r_b + 1'b1 < r_hi) begin
                                r_fsel  <= 1'b1;
                                r_state <= S_FETCH0;
                            end
                        end else begin
                            r_a <= r_a + 1'b1;
                            if (r_a + 1'b1 < r_mid) begin
                                r_fsel  <= 1'b0;
                                r_state <= S_FETCH0;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'b0, r_oindex};
    assign m_axis_tuser  = r_oflag;

endmodule

[rtl/zos_checker.sv]
// Port-level checker for the Z-order point sorter, bound to the top level.
module zos_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import zos_pkg::*;

    logic s_acc;
    logic unused_data;

    assign s_acc       = s_axis_tvalid && s_axis_tready;
    assign unused_data = ^s_axis_tdata;

    // an invalid index word carries a zero index
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
        else $error("invalid index word with nonzero index");

    // a rising result word follows an accepted read word, through the read data state
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_acc && s_axis_tuser == CMD_READ, 2))
        else $error("result word without a read word");

    // the last load starts the sort, which stalls the input
    a_sort_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_axis_tuser == CMD_LOAD && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after the last load");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

endmodule

bind z_order_point_sort zos_checker u_zos_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
